// ===== design/lfbrf_pkg.sv =====
package lfbrf_pkg;

  localparam int OpW      = 2;
  localparam int LenW     = 12;
  localparam int ByteW    = 8;
  localparam int StW      = 2;
  localparam int CntW     = 12;
  localparam int HdrBytes = 4;

  localparam logic [OpW-1:0] OpOpen  = 2'd0;
  localparam logic [OpW-1:0] OpWrite = 2'd1;
  localparam logic [OpW-1:0] OpRead  = 2'd2;

  localparam logic [StW-1:0] StOk    = 2'd0;
  localparam logic [StW-1:0] StError = 2'd1;
  localparam logic [StW-1:0] StFull  = 2'd2;
  localparam logic [StW-1:0] StEmpty = 2'd3;

  typedef struct packed {
    logic [StW-1:0]   status;
    logic [ByteW-1:0] data_out;
    logic             last_byte;
    logic [LenW-1:0]  read_len;
    logic [CntW-1:0]  entries_now;
    logic [CntW-1:0]  entries_peak;
    logic [CntW-1:0]  bytes_used_now;
    logic [CntW-1:0]  bytes_used_peak;
  } res_t;

endpackage

// ===== design/lfbrf_if.sv =====
interface lfbrf_in_if;
  logic                        valid;
  logic                        ready;
  logic [lfbrf_pkg::OpW-1:0]   op;
  logic [lfbrf_pkg::LenW-1:0]  msg_len;
  logic [lfbrf_pkg::ByteW-1:0] data_in;

  modport source (output valid, op, msg_len, data_in, input ready);
  modport sink (input valid, op, msg_len, data_in, output ready);
endinterface

interface lfbrf_out_if;
  logic                        valid;
  logic                        ready;
  logic [lfbrf_pkg::StW-1:0]   status;
  logic [lfbrf_pkg::ByteW-1:0] data_out;
  logic                        last_byte;
  logic [lfbrf_pkg::LenW-1:0]  read_len;
  logic [lfbrf_pkg::CntW-1:0]  entries_now;
  logic [lfbrf_pkg::CntW-1:0]  entries_peak;
  logic [lfbrf_pkg::CntW-1:0]  bytes_used_now;
  logic [lfbrf_pkg::CntW-1:0]  bytes_used_peak;

  modport source (output valid, status, data_out, last_byte, read_len, entries_now,
                  entries_peak, bytes_used_now, bytes_used_peak, input ready);
  modport sink (input valid, status, data_out, last_byte, read_len, entries_now,
                entries_peak, bytes_used_now, bytes_used_peak, output ready);
endinterface

// ===== design/lfbrf_ram.sv =====
module lfbrf_ram #(
  parameter int Depth = 4096,
  parameter int AddrW = 12
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AddrW-1:0]            waddr_i,
  input  logic [lfbrf_pkg::ByteW-1:0] wdata_i,
  input  logic                        re_i,
  input  logic [AddrW-1:0]            raddr_i,
  output logic [lfbrf_pkg::ByteW-1:0] rdata_o
);

  logic [lfbrf_pkg::ByteW-1:0] mem [Depth];
  logic [lfbrf_pkg::ByteW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/lfbrf_ctrl.sv =====
module lfbrf_ctrl #(
  parameter int RingBytes = 4096,
  parameter int AddrW = 12
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  lfbrf_in_if.sink                    in_i,
  input  logic                        slot_free_i,
  output logic                        res_valid_o,
  output lfbrf_pkg::res_t             res_o,
  output logic                        mem_we_o,
  output logic [AddrW-1:0]            mem_waddr_o,
  output logic [lfbrf_pkg::ByteW-1:0] mem_wdata_o,
  output logic                        mem_re_o,
  output logic [AddrW-1:0]            mem_raddr_o,
  input  logic [lfbrf_pkg::ByteW-1:0] mem_rdata_i
);

  localparam int SumW = ((AddrW > lfbrf_pkg::LenW) ? AddrW : lfbrf_pkg::LenW) + 2;
  localparam logic [AddrW:0] RingSz = (AddrW + 1)'(RingBytes);
  localparam int LenW = lfbrf_pkg::LenW;

  typedef enum logic [2:0] {
    S_IDLE,
    S_HDR,
    S_H0,
    S_H1,
    S_RD
  } state_e;

  function automatic logic [AddrW-1:0] ring_add(input logic [AddrW-1:0] a,
                                                input logic [AddrW-1:0] n);
    logic [AddrW:0] sum;
    sum = {1'b0, a} + {1'b0, n};
    if (sum >= RingSz) begin
      sum = sum - RingSz;
    end
    return sum[AddrW-1:0];
  endfunction

  state_e           state_q, state_d;
  logic [AddrW-1:0] read_ptr_q, read_ptr_d;
  logic [AddrW-1:0] commit_ptr_q, commit_ptr_d;
  logic [AddrW-1:0] write_ptr_q, write_ptr_d;
  logic [AddrW-1:0] data_ptr_q, data_ptr_d;
  logic [LenW-1:0]  write_left_q, write_left_d;
  logic             write_open_q, write_open_d;
  logic [LenW-1:0]  read_left_q, read_left_d;
  logic             read_open_q, read_open_d;
  logic [LenW-1:0]  cur_len_q, cur_len_d;
  logic [AddrW-1:0] wsize_q, wsize_d;
  logic [AddrW-1:0] entry_q, entry_d;
  logic [AddrW-1:0] entry_peak_q, entry_peak_d;
  logic [AddrW-1:0] usage_q, usage_d;
  logic [AddrW-1:0] usage_peak_q, usage_peak_d;
  logic [lfbrf_pkg::ByteW-1:0] hdr_hi_q, hdr_hi_d;
  logic [lfbrf_pkg::ByteW-1:0] hdr_lo_q, hdr_lo_d;

  logic [AddrW:0]   diff;
  logic [AddrW-1:0] used;
  logic             len_bad;
  logic             no_room;
  logic [LenW-1:0]  hdr_len;
  logic [AddrW-1:0] ptr_next;
  logic [AddrW-1:0] size;
  logic [AddrW-1:0] entry_nx;
  logic [AddrW-1:0] usage_nx;
  logic [lfbrf_pkg::StW-1:0]   status;
  logic [lfbrf_pkg::ByteW-1:0] dout;
  logic                        last;

  always_comb begin
    diff = {1'b0, commit_ptr_q} - {1'b0, read_ptr_q};
    if (read_ptr_q > commit_ptr_q) begin
      diff = diff + RingSz;
    end
    used    = diff[AddrW-1:0];
    len_bad = (in_i.msg_len == '0) ||
              (SumW'(in_i.msg_len) > SumW'(RingBytes - 5));
    no_room = (SumW'(used) + SumW'(in_i.msg_len) + SumW'(lfbrf_pkg::HdrBytes)) >=
              SumW'(RingBytes);
    hdr_len = {mem_rdata_i[LenW-lfbrf_pkg::ByteW-1:0], hdr_lo_q};
  end

  always_comb begin
    state_d      = state_q;
    read_ptr_d   = read_ptr_q;
    commit_ptr_d = commit_ptr_q;
    write_ptr_d  = write_ptr_q;
    data_ptr_d   = data_ptr_q;
    write_left_d = write_left_q;
    write_open_d = write_open_q;
    read_left_d  = read_left_q;
    read_open_d  = read_open_q;
    cur_len_d    = cur_len_q;
    wsize_d      = wsize_q;
    entry_d      = entry_q;
    entry_peak_d = entry_peak_q;
    usage_d      = usage_q;
    usage_peak_d = usage_peak_q;
    hdr_hi_d     = hdr_hi_q;
    hdr_lo_d     = hdr_lo_q;
    ptr_next     = ring_add(data_ptr_q, AddrW'(1));
    size         = AddrW'(cur_len_q) + AddrW'(lfbrf_pkg::HdrBytes);
    entry_nx     = entry_q + AddrW'(1);
    usage_nx     = usage_q + wsize_q;
    in_i.ready   = 1'b0;
    res_valid_o  = 1'b0;
    status       = lfbrf_pkg::StError;
    dout         = '0;
    last         = 1'b0;
    mem_we_o     = 1'b0;
    mem_waddr_o  = commit_ptr_q;
    mem_wdata_o  = in_i.msg_len[lfbrf_pkg::ByteW-1:0];
    mem_re_o     = 1'b0;
    mem_raddr_o  = data_ptr_q;

    case (state_q)
      S_IDLE: begin
        in_i.ready = slot_free_i;
        if (in_i.valid && slot_free_i) begin
          res_valid_o = 1'b1;
          case (in_i.op)
            lfbrf_pkg::OpOpen: begin
              if (write_open_q || len_bad) begin
                status = lfbrf_pkg::StError;
              end else if (no_room) begin
                status = lfbrf_pkg::StFull;
              end else begin
                status       = lfbrf_pkg::StOk;
                mem_we_o     = 1'b1;
                hdr_hi_d     = lfbrf_pkg::ByteW'(in_i.msg_len[LenW-1:lfbrf_pkg::ByteW]);
                write_ptr_d  = ring_add(commit_ptr_q, AddrW'(lfbrf_pkg::HdrBytes));
                write_left_d = in_i.msg_len;
                wsize_d      = AddrW'(in_i.msg_len) + AddrW'(lfbrf_pkg::HdrBytes);
                write_open_d = 1'b1;
                state_d      = S_HDR;
              end
            end
            lfbrf_pkg::OpWrite: begin
              if (write_open_q) begin
                status       = lfbrf_pkg::StOk;
                mem_we_o     = 1'b1;
                mem_waddr_o  = write_ptr_q;
                mem_wdata_o  = in_i.data_in;
                write_ptr_d  = ring_add(write_ptr_q, AddrW'(1));
                if (write_left_q != '0) begin
                  write_left_d = write_left_q - LenW'(1);
                end
                if (write_left_q <= LenW'(1)) begin
                  commit_ptr_d = ring_add(write_ptr_q, AddrW'(1));
                  write_open_d = 1'b0;
                  entry_d      = entry_nx;
                  usage_d      = usage_nx;
                  if (entry_nx > entry_peak_q) begin
                    entry_peak_d = entry_nx;
                  end
                  if (usage_nx > usage_peak_q) begin
                    usage_peak_d = usage_nx;
                  end
                end
              end
            end
            lfbrf_pkg::OpRead: begin
              if (read_open_q) begin
                res_valid_o = 1'b0;
                mem_re_o    = 1'b1;
                state_d     = S_RD;
              end else if (used >= AddrW'(lfbrf_pkg::HdrBytes)) begin
                res_valid_o = 1'b0;
                mem_re_o    = 1'b1;
                mem_raddr_o = read_ptr_q;
                state_d     = S_H0;
              end else begin
                status = lfbrf_pkg::StEmpty;
              end
            end
            default: begin
              status = lfbrf_pkg::StError;
            end
          endcase
        end
      end
      S_HDR: begin
        mem_we_o    = 1'b1;
        mem_waddr_o = ring_add(commit_ptr_q, AddrW'(1));
        mem_wdata_o = hdr_hi_q;
        state_d     = S_IDLE;
      end
      S_H0: begin
        hdr_lo_d    = mem_rdata_i;
        mem_re_o    = 1'b1;
        mem_raddr_o = ring_add(read_ptr_q, AddrW'(1));
        state_d     = S_H1;
      end
      S_H1: begin
        if (hdr_len == '0) begin
          res_valid_o = 1'b1;
          status      = lfbrf_pkg::StEmpty;
          state_d     = S_IDLE;
        end else begin
          cur_len_d   = hdr_len;
          read_left_d = hdr_len;
          read_open_d = 1'b1;
          data_ptr_d  = ring_add(read_ptr_q, AddrW'(lfbrf_pkg::HdrBytes));
          mem_re_o    = 1'b1;
          mem_raddr_o = data_ptr_d;
          state_d     = S_RD;
        end
      end
      S_RD: begin
        res_valid_o = 1'b1;
        status      = lfbrf_pkg::StOk;
        dout        = mem_rdata_i;
        read_left_d = read_left_q - LenW'(1);
        data_ptr_d  = ptr_next;
        if (read_left_q == LenW'(1)) begin
          last        = 1'b1;
          read_ptr_d  = ptr_next;
          read_open_d = 1'b0;
          if (entry_q != '0) begin
            entry_d = entry_q - AddrW'(1);
          end
          usage_d = (usage_q >= size) ? usage_q - size : '0;
        end
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res_o.status          = status;
    res_o.data_out        = dout;
    res_o.last_byte       = last;
    res_o.read_len        = cur_len_d;
    res_o.entries_now     = lfbrf_pkg::CntW'(entry_d);
    res_o.entries_peak    = lfbrf_pkg::CntW'(entry_peak_d);
    res_o.bytes_used_now  = lfbrf_pkg::CntW'(usage_d);
    res_o.bytes_used_peak = lfbrf_pkg::CntW'(usage_peak_d);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      read_ptr_q   <= '0;
      commit_ptr_q <= '0;
      write_ptr_q  <= '0;
      data_ptr_q   <= '0;
      write_left_q <= '0;
      write_open_q <= 1'b0;
      read_left_q  <= '0;
      read_open_q  <= 1'b0;
      cur_len_q    <= '0;
      entry_q      <= '0;
      entry_peak_q <= '0;
      usage_q      <= '0;
      usage_peak_q <= '0;
    end else begin
      state_q      <= state_d;
      read_ptr_q   <= read_ptr_d;
      commit_ptr_q <= commit_ptr_d;
      write_ptr_q  <= write_ptr_d;
      data_ptr_q   <= data_ptr_d;
      write_left_q <= write_left_d;
      write_open_q <= write_open_d;
      read_left_q  <= read_left_d;
      read_open_q  <= read_open_d;
      cur_len_q    <= cur_len_d;
      entry_q      <= entry_d;
      entry_peak_q <= entry_peak_d;
      usage_q      <= usage_d;
      usage_peak_q <= usage_peak_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wsize_q  <= wsize_d;
    hdr_hi_q <= hdr_hi_d;
    hdr_lo_q <= hdr_lo_d;
  end

endmodule

// ===== design/length_framed_byte_ring_fifo.sv =====
// Payload writes, rejected requests and empty reads are answered from idle; the result is registered.
// Opening a message writes the low length byte, then the high one in S_HDR, through the one write port.
// A read within an open message reads the RAM from idle and returns the byte in S_RD.
// The first byte of a message needs two header reads (S_H0, S_H1), then the payload read (S_RD).
// Asynchronous active-low reset clears pointers, counters and flags; ring contents stay.
module length_framed_byte_ring_fifo #(
  parameter int RingBytes = 4096
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lfbrf_in_if.sink    in_i,
  lfbrf_out_if.source out_o
);

  localparam int AddrW = $clog2(RingBytes);

  logic                        slot_free;
  logic                        res_valid;
  lfbrf_pkg::res_t             res;
  lfbrf_pkg::res_t             res_q;
  logic                        out_valid_q;
  logic                        mem_we;
  logic [AddrW-1:0]            mem_waddr;
  logic [lfbrf_pkg::ByteW-1:0] mem_wdata;
  logic                        mem_re;
  logic [AddrW-1:0]            mem_raddr;
  logic [lfbrf_pkg::ByteW-1:0] mem_rdata;

  assign slot_free = !out_valid_q || out_o.ready;

  lfbrf_ctrl #(
    .RingBytes(RingBytes),
    .AddrW    (AddrW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_i),
    .slot_free_i(slot_free),
    .res_valid_o(res_valid),
    .res_o      (res),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_re_o   (mem_re),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  lfbrf_ram #(
    .Depth(RingBytes),
    .AddrW(AddrW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      res_q <= res;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.status          = res_q.status;
  assign out_o.data_out        = res_q.data_out;
  assign out_o.last_byte       = res_q.last_byte;
  assign out_o.read_len        = res_q.read_len;
  assign out_o.entries_now     = res_q.entries_now;
  assign out_o.entries_peak    = res_q.entries_peak;
  assign out_o.bytes_used_now  = res_q.bytes_used_now;
  assign out_o.bytes_used_peak = res_q.bytes_used_peak;

endmodule

// ===== tb/sv/length_framed_byte_ring_fifo_test.sv =====
module length_framed_byte_ring_fifo_test;

  localparam int RingBytes = 4096;
  localparam int AddrW = $clog2(RingBytes);
  localparam int CycleLimit = 500000;
  localparam logic [lfbrf_pkg::OpW-1:0] OpReserved = 2'd3;

  logic clk_i;
  logic rst_ni;

  lfbrf_in_if  in_if();
  lfbrf_out_if out_if();

  length_framed_byte_ring_fifo #(
    .RingBytes(RingBytes)
  ) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  logic [lfbrf_pkg::ByteW-1:0] ring_mem [RingBytes];
  int unsigned rd_ptr, cm_ptr, wr_ptr, wr_left, rd_left, rd_len;
  int unsigned ent_cnt, ent_peak, use_cnt, use_peak;
  bit wr_open, rd_open;

  lfbrf_pkg::res_t ring_results_q[$];
  int status_seen[4];
  int msgs_read;
  int sent_count;
  int checked_count;
  int error_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [AddrW-1:0] ring_idx(input int unsigned pos);
    return AddrW'(pos % RingBytes);
  endfunction

  function automatic logic [lfbrf_pkg::LenW-1:0] rnd_len();
    return lfbrf_pkg::LenW'($urandom);
  endfunction

  function automatic logic [lfbrf_pkg::ByteW-1:0] rnd_byte();
    return lfbrf_pkg::ByteW'($urandom);
  endfunction

  function automatic lfbrf_pkg::res_t ring_fifo_step(input logic [lfbrf_pkg::OpW-1:0] op,
                                                     input logic [lfbrf_pkg::LenW-1:0] len,
                                                     input logic [lfbrf_pkg::ByteW-1:0] din);
    lfbrf_pkg::res_t r;
    int unsigned used, size, hl, ln;
    bit have;
    ln = 32'(len);
    r = '0;
    r.status = lfbrf_pkg::StError;
    case (op)
      lfbrf_pkg::OpOpen: begin
        if (wr_open || ln == 0 || ln > RingBytes - 5) begin
          r.status = lfbrf_pkg::StError;
        end else begin
          used = (cm_ptr + RingBytes - rd_ptr) % RingBytes;
          if (RingBytes - 1 - used < lfbrf_pkg::HdrBytes + ln) begin
            r.status = lfbrf_pkg::StFull;
          end else begin
            ring_mem[ring_idx(cm_ptr)] = len[7:0];
            ring_mem[ring_idx(cm_ptr + 1)] = {4'h0, len[11:8]};
            ring_mem[ring_idx(cm_ptr + 2)] = '0;
            ring_mem[ring_idx(cm_ptr + 3)] = '0;
            wr_ptr = (cm_ptr + lfbrf_pkg::HdrBytes) % RingBytes;
            wr_left = ln;
            wr_open = 1'b1;
            r.status = lfbrf_pkg::StOk;
          end
        end
      end
      lfbrf_pkg::OpWrite: begin
        if (wr_open) begin
          ring_mem[ring_idx(wr_ptr)] = din;
          wr_ptr = (wr_ptr + 1) % RingBytes;
          if (wr_left > 0) wr_left--;
          if (wr_left == 0) begin
            size = (wr_ptr + RingBytes - cm_ptr) % RingBytes;
            cm_ptr = wr_ptr;
            wr_open = 1'b0;
            ent_cnt++;
            if (ent_cnt > ent_peak) ent_peak = ent_cnt;
            use_cnt += size;
            if (use_cnt > use_peak) use_peak = use_cnt;
          end
          r.status = lfbrf_pkg::StOk;
        end
      end
      lfbrf_pkg::OpRead: begin
        have = rd_open;
        if (!have && (cm_ptr + RingBytes - rd_ptr) % RingBytes >= lfbrf_pkg::HdrBytes) begin
          hl = 32'({ring_mem[ring_idx(rd_ptr + 1)], ring_mem[ring_idx(rd_ptr)]});
          hl = hl & 32'hFFF;
          if (hl != 0) begin
            rd_len = hl;
            rd_left = hl;
            rd_open = 1'b1;
            have = 1'b1;
          end
        end
        if (!have) begin
          r.status = lfbrf_pkg::StEmpty;
        end else begin
          r.data_out = ring_mem[ring_idx(rd_ptr + lfbrf_pkg::HdrBytes + rd_len - rd_left)];
          rd_left--;
          if (rd_left == 0) begin
            size = lfbrf_pkg::HdrBytes + rd_len;
            r.last_byte = 1'b1;
            rd_ptr = (rd_ptr + size) % RingBytes;
            rd_open = 1'b0;
            if (ent_cnt > 0) ent_cnt--;
            use_cnt = (use_cnt >= size) ? use_cnt - size : 0;
          end
          r.status = lfbrf_pkg::StOk;
        end
      end
      default: r.status = lfbrf_pkg::StError;
    endcase
    r.read_len = rd_len[lfbrf_pkg::LenW-1:0];
    r.entries_now = ent_cnt[lfbrf_pkg::CntW-1:0];
    r.entries_peak = ent_peak[lfbrf_pkg::CntW-1:0];
    r.bytes_used_now = use_cnt[lfbrf_pkg::CntW-1:0];
    r.bytes_used_peak = use_peak[lfbrf_pkg::CntW-1:0];
    return r;
  endfunction

  task automatic push_op(input logic [lfbrf_pkg::OpW-1:0] op,
                         input logic [lfbrf_pkg::LenW-1:0] len,
                         input logic [lfbrf_pkg::ByteW-1:0] din);
    lfbrf_pkg::res_t want;
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.msg_len <= len;
    in_if.data_in <= din;
    @(posedge clk_i);
    while (in_if.ready !== 1'b1) @(posedge clk_i);
    want = ring_fifo_step(op, len, din);
    ring_results_q.push_back(want);
    status_seen[want.status]++;
    if (want.last_byte) msgs_read++;
    sent_count++;
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic check_field(input string name, input logic [lfbrf_pkg::CntW-1:0] got,
                             input logic [lfbrf_pkg::CntW-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d %s: got %0h, expected %0h",
                                checked_count, name, got, want));
    end
  endtask

  initial begin
    lfbrf_pkg::res_t want;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
        if (ring_results_q.size() == 0) begin
          report_mismatch("result transfer with nothing expected");
        end else begin
          want = ring_results_q.pop_front();
          check_field("status", lfbrf_pkg::CntW'(out_if.status),
                      lfbrf_pkg::CntW'(want.status));
          check_field("data_out", lfbrf_pkg::CntW'(out_if.data_out),
                      lfbrf_pkg::CntW'(want.data_out));
          check_field("last_byte", lfbrf_pkg::CntW'(out_if.last_byte),
                      lfbrf_pkg::CntW'(want.last_byte));
          check_field("read_len", out_if.read_len, want.read_len);
          check_field("entries_now", out_if.entries_now, want.entries_now);
          check_field("entries_peak", out_if.entries_peak, want.entries_peak);
          check_field("bytes_used_now", out_if.bytes_used_now, want.bytes_used_now);
          check_field("bytes_used_peak", out_if.bytes_used_peak, want.bytes_used_peak);
        end
        checked_count++;
      end
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("ERROR: timeout after %0d cycles, %0d results outstanding",
               cycle_count, ring_results_q.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic test_basic_cases();
    push_op(OpReserved, '1, '1);
    push_op(lfbrf_pkg::OpWrite, '0, 8'hFF);
    push_op(lfbrf_pkg::OpRead, '0, '0);
    push_op(lfbrf_pkg::OpOpen, '0, '0);
    push_op(lfbrf_pkg::OpOpen, lfbrf_pkg::LenW'(RingBytes - 4), '0);
    push_op(lfbrf_pkg::OpOpen, '1, '0);
    push_op(lfbrf_pkg::OpOpen, 12'd3, '0);
    push_op(lfbrf_pkg::OpOpen, 12'd1, '0);
    push_op(lfbrf_pkg::OpWrite, '0, 8'h00);
    push_op(lfbrf_pkg::OpRead, '0, '0);
    push_op(lfbrf_pkg::OpWrite, '0, 8'hFF);
    push_op(lfbrf_pkg::OpWrite, '0, 8'h5A);
    push_op(lfbrf_pkg::OpWrite, '0, 8'h00);
    push_op(lfbrf_pkg::OpOpen, 12'd1, '0);
    push_op(lfbrf_pkg::OpWrite, '0, 8'hA5);
    repeat (4) push_op(lfbrf_pkg::OpRead, '0, '0);
    push_op(lfbrf_pkg::OpRead, '1, '1);
    push_op(OpReserved, '0, '0);
  endtask

  // One message that takes the whole ring, so the free-space check is hit on both sides.
  task automatic test_full_ring();
    push_op(lfbrf_pkg::OpOpen, lfbrf_pkg::LenW'(RingBytes - 5), rnd_byte());
    push_op(lfbrf_pkg::OpRead, rnd_len(), rnd_byte());
    push_op(lfbrf_pkg::OpOpen, 12'd1, rnd_byte());
    repeat (RingBytes - 5) push_op(lfbrf_pkg::OpWrite, rnd_len(), rnd_byte());
    push_op(lfbrf_pkg::OpOpen, 12'd1, rnd_byte());
    repeat (RingBytes - 5) push_op(lfbrf_pkg::OpRead, rnd_len(), rnd_byte());
    push_op(lfbrf_pkg::OpRead, rnd_len(), rnd_byte());
  endtask

  task automatic test_random_traffic(input int n);
    int stop_at, len, cut, pick;
    logic [lfbrf_pkg::OpW-1:0] op;
    logic [lfbrf_pkg::LenW-1:0] bad_len;
    stop_at = sent_count + n;
    while (sent_count < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 70) begin
        pick = $urandom_range(99);
        if (pick < 60) len = $urandom_range(1, 8);
        else if (pick < 85) len = $urandom_range(9, 64);
        else if (pick < 99) len = $urandom_range(65, 300);
        else len = $urandom_range(301, 800);
        cut = ($urandom_range(99) < 8) ? $urandom_range(0, len - 1) : len;
        push_op(lfbrf_pkg::OpOpen, lfbrf_pkg::LenW'(len), rnd_byte());
        repeat (cut) begin
          push_op(lfbrf_pkg::OpWrite, rnd_len(), rnd_byte());
          if ($urandom_range(99) < 45) push_op(lfbrf_pkg::OpRead, rnd_len(), rnd_byte());
        end
      end else if (pick < 85) begin
        repeat ($urandom_range(1, 40)) push_op(lfbrf_pkg::OpRead, rnd_len(), rnd_byte());
      end else begin
        op = lfbrf_pkg::OpW'($urandom_range(0, 3));
        bad_len = rnd_len();
        if (op == lfbrf_pkg::OpOpen && !wr_open) begin
          bad_len = ($urandom_range(1) != 0) ?
                    lfbrf_pkg::LenW'($urandom_range(RingBytes - 4, 4095)) : '0;
        end
        push_op(op, bad_len, rnd_byte());
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    in_if.valid <= 1'b0;
    in_if.op <= lfbrf_pkg::OpRead;
    in_if.msg_len <= '0;
    in_if.data_in <= '0;
    foreach (ring_mem[i]) ring_mem[i] = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 32;
    recv_stall_pct = 32;
    test_basic_cases();

    send_idle_pct = 0;
    recv_stall_pct = 0;
    test_full_ring();
    test_random_traffic(200);

    send_idle_pct = 87;
    test_random_traffic(200);

    send_idle_pct = 0;
    recv_stall_pct = 87;
    test_random_traffic(200);

    send_idle_pct = 32;
    recv_stall_pct = 32;
    test_random_traffic(200);

    in_if.valid <= 1'b0;
    while (ring_results_q.size() != 0) @(posedge clk_i);
    recv_stall_pct = 0;
    repeat (10) @(posedge clk_i);

    $display("Sent %0d transfers and checked %0d results over four idling phases;",
             sent_count, checked_count);
    $display("%0d messages read back, %0d ok, %0d error, %0d full, %0d empty responses.",
             msgs_read, status_seen[lfbrf_pkg::StOk], status_seen[lfbrf_pkg::StError],
             status_seen[lfbrf_pkg::StFull], status_seen[lfbrf_pkg::StEmpty]);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/lfbrf_pkg.sv
design/lfbrf_if.sv
design/lfbrf_ram.sv
design/lfbrf_ctrl.sv
design/length_framed_byte_ring_fifo.sv
tb/sv/length_framed_byte_ring_fifo_test.sv
